// ===== hdl/stl_pkg.sv =====
package stl_pkg;

    localparam int TABLE_DEPTH_DEF = 1024;

    localparam int TIME_W = 32;
    localparam int IDX_W  = 10;
    localparam int OP_W   = 2;
    localparam int ST_W   = 2;

    localparam logic [OP_W-1:0] OP_CLEAR  = 2'd0;
    localparam logic [OP_W-1:0] OP_APPEND = 2'd1;
    localparam logic [OP_W-1:0] OP_FIND   = 2'd2;
    localparam logic [OP_W-1:0] OP_READ   = 2'd3;

    localparam logic [ST_W-1:0] ST_OK    = 2'd0;
    localparam logic [ST_W-1:0] ST_RANGE = 2'd1;
    localparam logic [ST_W-1:0] ST_EMPTY = 2'd2;
    localparam logic [ST_W-1:0] ST_FULL  = 2'd3;

    // controller -> datapath
    typedef struct packed {
        logic accept;
        logic search_step;
        logic cur_step;
        logic prev_step;
        logic out_load;
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            count_zero;
        logic            search_last;
        logic            p_at_end;
        logic            cur_final;
    } stat_t;

endpackage

// ===== hdl/sorted_time_table_index_lookup.sv =====
// channel  direction  handshake            beat payload
// in       sink       in_valid / in_stall  op, time_value, read_index, choose_nearest
// out      source     out_valid/out_stall  found_index, time_out, status
//
// Clear, append, read and a find on an empty table go straight to the output
// register. A find probes the table by binary search, then reads the lower bound
// when it lies inside the table and, in nearest mode, may read its earlier
// neighbour; probes is at most floor(log2(entries))+1, all through the single
// registered read port of the table. One item is in work at a time. Reset empties
// the table at once. A stalled result waits in the output register.
module sorted_time_table_index_lookup #(
    parameter int TABLE_DEPTH = stl_pkg::TABLE_DEPTH_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [stl_pkg::OP_W-1:0]          op,
    input  logic signed [stl_pkg::TIME_W-1:0] time_value,
    input  logic [stl_pkg::IDX_W-1:0]         read_index,
    input  logic                              choose_nearest,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [stl_pkg::IDX_W-1:0]         found_index,
    output logic signed [stl_pkg::TIME_W-1:0] time_out,
    output logic [stl_pkg::ST_W-1:0]          status
);

    stl_pkg::cmd_t  cmd;
    stl_pkg::stat_t stat;

    stl_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd),
        .stat      (stat)
    );

    stl_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .stat           (stat),
        .op             (op),
        .time_value     (time_value),
        .read_index     (read_index),
        .choose_nearest (choose_nearest),
        .found_index    (found_index),
        .time_out       (time_out),
        .status         (status)
    );

    // one item at a time: an accepted beat leaves the input stalled next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("input accepted while an item was in work");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status != stl_pkg::ST_OK)) |-> (time_out == '0))
        else $error("non-zero time on a failed beat");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status == stl_pkg::ST_EMPTY)) |-> (found_index == '0))
        else $error("index reported for an empty table");

endmodule

// ===== hdl/stl_datapath.sv =====
module stl_datapath #(
    parameter int TABLE_DEPTH = stl_pkg::TABLE_DEPTH_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  stl_pkg::cmd_t                     cmd,
    output stl_pkg::stat_t                    stat,
    input  logic [stl_pkg::OP_W-1:0]          op,
    input  logic signed [stl_pkg::TIME_W-1:0] time_value,
    input  logic [stl_pkg::IDX_W-1:0]         read_index,
    input  logic                              choose_nearest,
    output logic [stl_pkg::IDX_W-1:0]         found_index,
    output logic signed [stl_pkg::TIME_W-1:0] time_out,
    output logic [stl_pkg::ST_W-1:0]          status
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int RW = (CW > stl_pkg::IDX_W) ? CW : stl_pkg::IDX_W;
    localparam int TW = stl_pkg::TIME_W;
    localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

    logic signed [TW-1:0] mem [TABLE_DEPTH];

    logic [CW-1:0]             count_reg;
    logic [CW-1:0]             count_next;
    logic [CW-1:0]             first_reg;
    logic [CW-1:0]             len_reg;
    logic [CW-1:0]             idx_reg;
    logic [stl_pkg::OP_W-1:0]  op_reg;
    logic [stl_pkg::ST_W-1:0]  status_reg;
    logic signed [TW-1:0]      q_reg;
    logic                      nearest_reg;
    logic [TW:0]               dcur_reg;
    logic signed [TW-1:0]      rd_data_reg;
    logic [stl_pkg::IDX_W-1:0] found_index_reg;
    logic signed [TW-1:0]      time_out_reg;
    logic [stl_pkg::ST_W-1:0]  status_out_reg;

    logic                 table_full;
    logic                 count_zero;
    logic [RW-1:0]        ridx_ext;
    logic                 read_ok;
    logic [CW-1:0]        half_count;
    logic [CW-1:0]        half;
    logic [CW-1:0]        mid;
    logic                 lt;
    logic [CW-1:0]        first_lt;
    logic [CW-1:0]        len_lt;
    logic [CW-1:0]        mid_lt;
    logic [CW-1:0]        mid_ge;
    logic [CW-1:0]        first_n;
    logic [CW-1:0]        len_n;
    logic [CW-1:0]        mid_n;
    logic [CW-1:0]        p_minus1;
    logic signed [TW:0]   diff;
    logic [TW:0]          dabs;
    logic                 cur_final;
    logic                 wr_en;
    logic                 rd_en;
    logic [AW-1:0]        rd_addr;
    logic [RW-1:0]        idx_ext;
    logic [stl_pkg::ST_W-1:0] status_in;

    assign table_full = (count_reg == DEPTH_C);
    assign count_zero = (count_reg == '0);
    assign ridx_ext   = RW'(read_index);
    assign read_ok    = (ridx_ext < RW'(count_reg));
    assign half_count = count_reg >> 1;

    // one halving step; both candidate midpoints are formed ahead of the compare
    assign half     = len_reg >> 1;
    assign mid      = first_reg + half;
    assign lt       = (rd_data_reg < q_reg);
    assign first_lt = mid + CW'(1);
    assign len_lt   = len_reg - half - CW'(1);
    assign mid_lt   = first_lt + (len_lt >> 1);
    assign mid_ge   = first_reg + (half >> 1);
    assign first_n  = lt ? first_lt : first_reg;
    assign len_n    = lt ? len_lt : half;
    assign mid_n    = lt ? mid_lt : mid_ge;
    assign p_minus1 = first_reg - CW'(1);

    assign diff = {rd_data_reg[TW-1], rd_data_reg} - {q_reg[TW-1], q_reg};
    assign dabs = diff[TW] ? (TW+1)'(-diff) : (TW+1)'(diff);

    assign cur_final = (rd_data_reg == q_reg) || (first_reg == '0) || !nearest_reg;

    assign stat.op          = op;
    assign stat.count_zero  = count_zero;
    assign stat.search_last = (len_n == '0);
    assign stat.p_at_end    = (first_n == count_reg);
    assign stat.cur_final   = cur_final;

    assign wr_en = cmd.accept && (op == stl_pkg::OP_APPEND) && !table_full;

    always_comb
    begin
        rd_en   = 1'b0;
        rd_addr = '0;
        if (cmd.accept)
        begin
            if (op == stl_pkg::OP_READ)
            begin
                rd_en   = read_ok;
                rd_addr = ridx_ext[AW-1:0];
            end
            else if (op == stl_pkg::OP_FIND)
            begin
                rd_en   = !count_zero;
                rd_addr = half_count[AW-1:0];
            end
        end
        else if (cmd.search_step)
        begin
            if (len_n != '0)
            begin
                rd_en   = 1'b1;
                rd_addr = mid_n[AW-1:0];
            end
            else
            begin
                rd_en   = (first_n != count_reg);
                rd_addr = first_n[AW-1:0];
            end
        end
        else if (cmd.cur_step)
        begin
            rd_en   = !cur_final;
            rd_addr = p_minus1[AW-1:0];
        end
    end

    always_comb
    begin
        unique case (op)
            stl_pkg::OP_CLEAR:  status_in = stl_pkg::ST_OK;
            stl_pkg::OP_APPEND: status_in = table_full ? stl_pkg::ST_FULL : stl_pkg::ST_OK;
            stl_pkg::OP_FIND:   status_in = count_zero ? stl_pkg::ST_EMPTY : stl_pkg::ST_OK;
            stl_pkg::OP_READ:   status_in = read_ok ? stl_pkg::ST_OK : stl_pkg::ST_RANGE;
            default:            status_in = stl_pkg::ST_OK;
        endcase
    end

    always_comb
    begin
        count_next = count_reg;
        if (cmd.accept && (op == stl_pkg::OP_CLEAR))
        begin
            count_next = '0;
        end
        else if (wr_en)
        begin
            count_next = count_reg + CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[count_reg[AW-1:0]] <= time_value;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            op_reg      <= op;
            q_reg       <= time_value;
            nearest_reg <= choose_nearest;
            status_reg  <= status_in;
            first_reg   <= '0;
            len_reg     <= count_reg;
            idx_reg     <= '0;
        end
        if (cmd.search_step)
        begin
            first_reg <= first_n;
            len_reg   <= len_n;
            // query past the last entry: take the last index
            if ((len_n == '0) && (first_n == count_reg))
            begin
                idx_reg <= count_reg - CW'(1);
            end
        end
        if (cmd.cur_step)
        begin
            dcur_reg <= dabs;
            idx_reg  <= first_reg;
        end
        // a tie goes to the earlier entry
        if (cmd.prev_step && (dabs <= dcur_reg))
        begin
            idx_reg <= p_minus1;
        end
    end

    assign idx_ext = RW'(idx_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            found_index_reg <= ((op_reg == stl_pkg::OP_FIND) && (status_reg == stl_pkg::ST_OK))
                               ? idx_ext[stl_pkg::IDX_W-1:0] : '0;
            time_out_reg    <= ((op_reg == stl_pkg::OP_READ) && (status_reg == stl_pkg::ST_OK))
                               ? rd_data_reg : '0;
            status_out_reg  <= status_reg;
        end
    end

    assign found_index = found_index_reg;
    assign time_out    = time_out_reg;
    assign status      = status_out_reg;

endmodule

// ===== hdl/stl_ctrl.sv =====
module stl_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_stall,
    output logic           out_valid,
    input  logic           out_stall,
    output stl_pkg::cmd_t  cmd,
    input  stl_pkg::stat_t stat
);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_SEARCH = 5'b00010,
        S_CUR    = 5'b00100,
        S_PREV   = 5'b01000,
        S_DONE   = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    if ((stat.op == stl_pkg::OP_FIND) && !stat.count_zero)
                    begin
                        state_next = S_SEARCH;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
            end
            S_SEARCH:
            begin
                cmd.search_step = 1'b1;
                if (stat.search_last)
                begin
                    state_next = stat.p_at_end ? S_DONE : S_CUR;
                end
            end
            S_CUR:
            begin
                cmd.cur_step = 1'b1;
                state_next   = stat.cur_final ? S_DONE : S_PREV;
            end
            S_PREV:
            begin
                cmd.prev_step = 1'b1;
                state_next    = S_DONE;
            end
            S_DONE:
            begin
                // hold the result until the output register is free
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign out_valid_next = cmd.out_load || (out_valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule
